@@ hw/rtl/pid_controller_step_top_assert.svh @@
// Assertion macros for the checker of the PID step block.
`ifndef PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`define PID_CONTROLLER_STEP_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define PIDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define PIDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define PIDC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pidc_pkg.sv @@
// Shared types and constants of the PID step block.
package pidc_pkg;

  // Configuration port index width and register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_PERIOD = 3'd3,
    REG_FLOOR  = 3'd4,
    REG_CEIL   = 3'd5
  } pidc_reg_t;

  // Multiplier digit: bits of the second operand consumed per cycle
  localparam int MUL_DIGIT = 16;

  // Operations of the shared multiply/divide unit
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } pidc_op_t;

  typedef struct packed {
    logic     start;
    pidc_op_t op;
  } pidc_cmd_t;

endpackage

@@ hw/rtl/pidc_stream_if.sv @@
// Valid/ready channel interfaces for the PID step block.
interface pidc_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] target_value;
  logic signed [DATA_WIDTH-1:0] measured_value;

  modport source (output valid, output target_value, output measured_value, input ready);
  modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

interface pidc_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

@@ hw/rtl/pid_controller_step_top.sv @@
// PID step block: sequencer and datapath around one shared multiply/divide unit.
//
// One item (setpoint, measurement) gives one drive value. The block works on
// one item at a time: in_ch.ready is high only while the sequencer is idle.
// The work is done by the shared unit: four digit-serial multiplies with
// 16-bit digits (P, Ki*T, integrator increment, Kd*(e - e_prev)) and a
// one-bit-per-cycle restoring divide by the sample period, skipped when the
// derivative quotient is zero or saturates. A finished result waits in an
// output register, so the next item is taken while it is pending.
// Configuration writes take effect at once and belong in idle periods.
// Integrator and previous error clear on reset.
module pid_controller_step_top
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pidc_in_if.sink               in_ch,
  pidc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;

  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_PREP = 12'b0000_0000_0010,
    S_LOAD = 12'b0000_0000_0100,
    S_MUL  = 12'b0000_0000_1000,
    S_DCHK = 12'b0000_0001_0000,
    S_DIV  = 12'b0000_0010_0000,
    S_RND  = 12'b0000_0100_0000,
    S_SAT  = 12'b0000_1000_0000,
    S_INTA = 12'b0001_0000_0000,
    S_INTB = 12'b0010_0000_0000,
    S_SUM  = 12'b0100_0000_0000,
    S_CLMP = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    TERM_P   = 2'd0,
    TERM_KT  = 2'd1,
    TERM_INC = 2'd2,
    TERM_D   = 2'd3
  } term_t;

  // Configuration registers
  logic signed [W-1:0] kp, ki, kd, flo, fhi;
  logic [W-2:0]        tper;

  pidc_cfg #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (F)
  ) u_cfg (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (cfg_we),
    .idx  (cfg_index),
    .data (cfg_data),
    .kp   (kp),
    .ki   (ki),
    .kd   (kd),
    .tper (tper),
    .flo  (flo),
    .fhi  (fhi)
  );

  // Sequencer and datapath registers
  state_t              state_r, state_nxt;
  term_t               term_r, term_nxt;
  logic signed [W-1:0] e_r, e_nxt;
  logic signed [W-1:0] le_r, le_nxt;
  logic signed [W:0]   es_r, es_nxt;
  logic signed [W:0]   ed_r, ed_nxt;
  logic                neg_r, neg_nxt;
  logic [2*W-1:0]      q_r, q_nxt;
  logic signed [W-1:0] p_r, p_nxt;
  logic signed [W-1:0] kt_r, kt_nxt;
  logic signed [W-1:0] inc_r, inc_nxt;
  logic signed [W-1:0] d_r, d_nxt;
  logic signed [W-1:0] integ_r, integ_nxt;
  logic signed [W:0]   isum_r, isum_nxt;
  logic signed [W+1:0] sum_r, sum_nxt;
  logic [W-1:0]        out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Shared unit
  pidc_cmd_t      mdu_cmd;
  logic [W:0]     a_mag;
  logic [W-1:0]   b_mag;
  logic [2*W-1:0] prod;
  logic           mdu_done;

  pidc_mdu #(
    .DATA_WIDTH (W)
  ) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mdu_cmd),
    .a_in  (a_mag),
    .b_in  (b_mag),
    .dvs_in(tper),
    .prod  (prod),
    .done  (mdu_done)
  );

  // Error of the incoming item, saturated
  logic [W:0]   diff_in;
  logic [W-1:0] e_in;
  assign diff_in = {in_ch.target_value[W-1], in_ch.target_value}
                 - {in_ch.measured_value[W-1], in_ch.measured_value};
  assign e_in = (diff_in[W] != diff_in[W-1]) ? (diff_in[W] ? MIN_V : MAX_V)
                                             : diff_in[W-1:0];

  // Operand selection per term, then magnitudes and product sign
  logic [W:0]   a_sgn;
  logic [W-1:0] b_sgn;
  logic         neg_sel;

  always_comb begin
    unique case (term_r)
      TERM_P: begin
        a_sgn = {e_r[W-1], e_r};
        b_sgn = kp;
      end
      TERM_KT: begin
        a_sgn = {2'b00, tper};
        b_sgn = ki;
      end
      TERM_INC: begin
        a_sgn = es_r;
        b_sgn = kt_r;
      end
      TERM_D: begin
        a_sgn = ed_r;
        b_sgn = kd;
      end
      default: begin
        a_sgn = '0;
        b_sgn = '0;
      end
    endcase
  end

  assign a_mag   = a_sgn[W] ? (~a_sgn + (W+1)'(1)) : a_sgn;
  assign b_mag   = b_sgn[W-1] ? (~b_sgn + W'(1)) : b_sgn;
  assign neg_sel = a_sgn[W] ^ b_sgn[W-1];

  // Quotient checks before dividing: zero dividend, quotient of 2^W or more
  logic prod_zero, hi_ovf;
  assign prod_zero = (prod == '0);
  assign hi_ovf    = (prod[2*W-1:W] >= {1'b0, tper});

  // Scale and round toward minus infinity (magnitude plus one when negative and inexact)
  logic [2*W-1:0] qv, rnd_val;
  logic           inexact;

  always_comb begin
    unique case (term_r)
      TERM_D: begin
        qv      = (2*W)'(prod[W-1:0]);
        inexact = |prod[2*W-1:W];
      end
      TERM_INC: begin
        qv      = prod >> (F + 1);
        inexact = |prod[F:0];
      end
      default: begin
        qv      = prod >> F;
        inexact = |prod[F-1:0];
      end
    endcase
  end

  assign rnd_val = qv + (2*W)'(neg_r & inexact);

  // Saturate the signed result to W bits
  logic         pos_ovf, neg_ovf;
  logic [W-1:0] neg_q, sat_res;
  assign pos_ovf = |q_r[2*W-1:W-1];
  assign neg_ovf = (|q_r[2*W-1:W]) || (q_r[W-1] && (|q_r[W-2:0]));
  assign neg_q   = ~q_r[W-1:0] + W'(1);
  assign sat_res = neg_r ? (neg_ovf ? MIN_V : neg_q)
                         : (pos_ovf ? MAX_V : q_r[W-1:0]);

  // Clamp to output limits, shared by integrator and output
  logic signed [W+1:0] clamp_in, hi_x, lo_x;
  logic [W-1:0]        clamp_res;
  assign hi_x      = {{2{fhi[W-1]}}, fhi};
  assign lo_x      = {{2{flo[W-1]}}, flo};
  assign clamp_in  = (state_r == S_INTB) ? {isum_r[W], isum_r} : sum_r;
  assign clamp_res = (clamp_in > hi_x) ? fhi :
                     (clamp_in < lo_x) ? flo : clamp_in[W-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    term_nxt      = term_r;
    e_nxt         = e_r;
    le_nxt        = le_r;
    es_nxt        = es_r;
    ed_nxt        = ed_r;
    neg_nxt       = neg_r;
    q_nxt         = q_r;
    p_nxt         = p_r;
    kt_nxt        = kt_r;
    inc_nxt       = inc_r;
    d_nxt         = d_r;
    integ_nxt     = integ_r;
    isum_nxt      = isum_r;
    sum_nxt       = sum_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mdu_cmd       = '{start: 1'b0, op: OP_MUL};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          e_nxt     = e_in;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        es_nxt    = {e_r[W-1], e_r} + {le_r[W-1], le_r};
        ed_nxt    = {e_r[W-1], e_r} - {le_r[W-1], le_r};
        le_nxt    = e_r;
        term_nxt  = TERM_P;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        mdu_cmd   = '{start: 1'b1, op: OP_MUL};
        neg_nxt   = neg_sel;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mdu_done) begin
          state_nxt = (term_r == TERM_D) ? S_DCHK : S_RND;
        end
      end
      S_DCHK: begin
        priority if (prod_zero) begin
          q_nxt     = '0;
          state_nxt = S_SAT;
        end else if (hi_ovf) begin
          q_nxt     = '1;
          state_nxt = S_SAT;
        end else begin
          mdu_cmd   = '{start: 1'b1, op: OP_DIV};
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (mdu_done) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        q_nxt     = rnd_val;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        unique case (term_r)
          TERM_P: begin
            p_nxt     = sat_res;
            term_nxt  = TERM_KT;
            state_nxt = S_LOAD;
          end
          TERM_KT: begin
            kt_nxt    = sat_res;
            term_nxt  = TERM_INC;
            state_nxt = S_LOAD;
          end
          TERM_INC: begin
            inc_nxt   = sat_res;
            state_nxt = S_INTA;
          end
          TERM_D: begin
            d_nxt     = sat_res;
            state_nxt = S_SUM;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INTA: begin
        isum_nxt  = {integ_r[W-1], integ_r} + {inc_r[W-1], inc_r};
        state_nxt = S_INTB;
      end
      S_INTB: begin
        integ_nxt = clamp_res;
        term_nxt  = TERM_D;
        state_nxt = S_LOAD;
      end
      S_SUM: begin
        sum_nxt   = {{2{p_r[W-1]}}, p_r} + {{2{integ_r[W-1]}}, integ_r}
                  + {{2{d_r[W-1]}}, d_r};
        state_nxt = S_CLMP;
      end
      S_CLMP: begin
        // hold here while the previous result is still waiting
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt  = clamp_res;
          out_valid_nxt = 1'b1;
          term_nxt      = TERM_P;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= TERM_P;
      le_r        <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      le_r        <= le_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working values
  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    es_r       <= es_nxt;
    ed_r       <= ed_nxt;
    neg_r      <= neg_nxt;
    q_r        <= q_nxt;
    p_r        <= p_nxt;
    kt_r       <= kt_nxt;
    inc_r      <= inc_nxt;
    d_r        <= d_nxt;
    isum_r     <= isum_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = out_data_r;

endmodule

@@ hw/rtl/pidc_cfg.sv @@
// Configuration registers: gains, sample period and output limits.
module pidc_cfg
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  logic [CFG_IDX_W-1:0]         idx,
  input  logic [DATA_WIDTH-1:0]        data,
  output logic signed [DATA_WIDTH-1:0] kp,
  output logic signed [DATA_WIDTH-1:0] ki,
  output logic signed [DATA_WIDTH-1:0] kd,
  output logic [DATA_WIDTH-2:0]        tper,
  output logic signed [DATA_WIDTH-1:0] flo,
  output logic signed [DATA_WIDTH-1:0] fhi
);

  localparam int W = DATA_WIDTH;

  // Reset values: period 1.0, limits at the full signed range
  localparam logic [W-2:0] TP_RST  = {{(W-2){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [W-1:0] MIN_RST = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_RST = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0] kp_r, ki_r, kd_r, flo_r, fhi_r;
  logic [W-1:0] kp_nxt, ki_nxt, kd_nxt, flo_nxt, fhi_nxt;
  logic [W-2:0] tp_r, tp_nxt;

  // Write decode; unknown indexes are dropped
  always_comb begin
    kp_nxt  = kp_r;
    ki_nxt  = ki_r;
    kd_nxt  = kd_r;
    tp_nxt  = tp_r;
    flo_nxt = flo_r;
    fhi_nxt = fhi_r;
    if (we) begin
      unique case (idx)
        REG_KP:     kp_nxt  = data;
        REG_KI:     ki_nxt  = data;
        REG_KD:     kd_nxt  = data;
        REG_PERIOD: tp_nxt  = data[W-2:0];
        REG_FLOOR:  flo_nxt = data;
        REG_CEIL:   fhi_nxt = data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      ki_r  <= '0;
      kd_r  <= '0;
      tp_r  <= TP_RST;
      flo_r <= MIN_RST;
      fhi_r <= MAX_RST;
    end else begin
      kp_r  <= kp_nxt;
      ki_r  <= ki_nxt;
      kd_r  <= kd_nxt;
      tp_r  <= tp_nxt;
      flo_r <= flo_nxt;
      fhi_r <= fhi_nxt;
    end
  end

  assign kp   = kp_r;
  assign ki   = ki_r;
  assign kd   = kd_r;
  assign tper = tp_r;
  assign flo  = flo_r;
  assign fhi  = fhi_r;

endmodule

@@ hw/rtl/pidc_mdu.sv @@
// Shared multiply/divide unit: digit-serial multiply, restoring divide.
module pidc_mdu
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pidc_cmd_t                 cmd,
  input  logic [DATA_WIDTH:0]       a_in,
  input  logic [DATA_WIDTH-1:0]     b_in,
  input  logic [DATA_WIDTH-2:0]     dvs_in,
  output logic [2*DATA_WIDTH-1:0]   prod,
  output logic                      done
);

  localparam int W   = DATA_WIDTH;
  localparam int DIG = MUL_DIGIT;
  localparam int ND  = (W + DIG - 1) / DIG;
  localparam int BP  = ND * DIG;
  localparam int AW  = W + 1 + BP;
  localparam int CW  = $clog2(W + 1);

  logic [AW-1:0] acc_r, acc_nxt;
  logic [W:0]    a_r, a_nxt;
  logic [BP-1:0] b_r, b_nxt;
  logic [W-2:0]  dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  pidc_op_t      op_r, op_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  // Multiply step: shift accumulator one digit, add operand times top digit
  logic [W+DIG:0] mp;
  logic [AW-1:0]  mul_acc;
  assign mp      = a_r * b_r[BP-1 -: DIG];
  assign mul_acc = {acc_r[AW-DIG-1:0], {DIG{1'b0}}} + AW'(mp);

  // Divide step: remainder in the upper half, quotient shifts into the lower
  logic [W:0]    dtry, dv_ext, dsub;
  logic          ge;
  logic [W-1:0]  rem_new;
  logic [AW-1:0] div_acc;
  assign dtry    = {acc_r[2*W-1:W], acc_r[W-1]};
  assign dv_ext  = {2'b00, dv_r};
  assign ge      = (dtry >= dv_ext);
  assign dsub    = dtry - dv_ext;
  assign rem_new = ge ? dsub[W-1:0] : dtry[W-1:0];
  assign div_acc = AW'({rem_new, acc_r[W-2:0], ge});

  // Sequencing of the unit
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      op_nxt   = cmd.op;
      busy_nxt = 1'b1;
      if (cmd.op == OP_MUL) begin
        acc_nxt = '0;
        a_nxt   = a_in;
        b_nxt   = BP'(b_in);
        cnt_nxt = CW'(ND);
      end else begin
        dv_nxt  = dvs_in;
        cnt_nxt = CW'(W);
      end
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          acc_nxt = mul_acc;
          b_nxt   = b_r << DIG;
        end
        OP_DIV: acc_nxt = div_acc;
        default: ;
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  // Operand and accumulator storage
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    dv_r  <= dv_nxt;
  end

  assign prod = acc_r[2*W-1:0];
  assign done = done_r;

endmodule

@@ hw/rtl/pidc_chk.sv @@
// Port-level checker for the PID step block, bound to the top level.
`include "pid_controller_step_top_assert.svh"

module pidc_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] drive_value
);

  // One item at a time: taking an item closes the input
  `PIDC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready high after item")

  // A stalled result stays and keeps its value
  `PIDC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_value), "result lost while stalled")

  // A new result only comes out of an item in progress
  `PIDC_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without work")

  // Reset leaves the block idle and empty
  `PIDC_ASSERT_RST(a_reset_idle, !rst_n, in_ready && !out_valid, "not idle after reset")

endmodule

bind pid_controller_step_top pidc_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pidc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .drive_value(out_ch.drive_value)
);
